// ----- sv/ddac_spi_pkg.sv -----
`timescale 1ns / 1ps

package ddac_spi_pkg;

   // Field and register widths
   localparam int OP_W      = 2;
   localparam int CHAN_W    = 8;
   localparam int VALUE_W   = 16;
   localparam int HALF_W    = 16;
   localparam int GUARD_W   = 16;
   localparam int WAIT_W    = 20;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 20;

   // Frame layout: command in [23:19], address in [18:16], data in [15:0]
   localparam int FRAME_BITS = 24;
   localparam int BITS_W     = $clog2(FRAME_BITS + 1);
   localparam int CMD_W      = 5;
   localparam int ADDR_W     = 3;
   localparam logic [CMD_W-1:0] CMD_WRITE_UPDATE = 5'd3;

   // Request operations
   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 2'd0,
      OP_INIT     = 2'd1,
      OP_WRITE    = 2'd2,
      OP_WRITE_MV = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_WAIT  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_WAIT = 8'd3;

   // Register reset values
   localparam logic [HALF_W-1:0]  HALF_RST   = 16'd1000;
   localparam logic [GUARD_W-1:0] GUARD_RST  = 16'd10000;
   localparam logic [WAIT_W-1:0]  POWER_RST  = 20'd10000;
   localparam logic [WAIT_W-1:0]  SETTLE_RST = 20'd300000;

   // Millivolt scaling: code = 32768 + floor(mv * 32678 / 10000), mv <= 3000.
   // The divide is a multiply by a rounded-up reciprocal scaled by 2^MV_SHIFT;
   // the rounding error stays far below 1/10000 over the millivolt range.
   localparam int MV_W     = 12;
   localparam int MV_SHIFT = 26;
   localparam int MV_NUM   = 32678;
   localparam int MV_DEN   = 10000;
   localparam int RECIP_W  = 28;
   localparam int SCALED_W = 14;
   localparam logic [MV_W-1:0] MV_MAX = 12'd3000;
   localparam logic [VALUE_W-1:0] MV_OFFSET = 16'd32768;
   localparam logic [RECIP_W-1:0] MV_RECIP =
      RECIP_W'(((64'(MV_NUM) << MV_SHIFT) + 64'(MV_DEN) - 64'd1) / 64'(MV_DEN));

   // Init frames: power up A and B, LDAC inactive, internal reference
   localparam logic [FRAME_BITS-1:0] FRAME_POWER_UP = 24'h200003;
   localparam logic [FRAME_BITS-1:0] FRAME_LDAC     = 24'h300003;
   localparam logic [FRAME_BITS-1:0] FRAME_INT_REF  = 24'h380001;

   // Frame chosen from the init frame index after it is decremented
   function automatic logic [FRAME_BITS-1:0] init_frame(input logic [1:0] idx);
      logic [FRAME_BITS-1:0] word;
      case (idx)
         2'd1:    word = FRAME_LDAC;
         2'd0:    word = FRAME_INT_REF;
         default: word = FRAME_POWER_UP;
      endcase
      return word;
   endfunction

   // One result transfer
   typedef struct packed {
      logic chip_select;
      logic serial_clock;
      logic serial_data;
      logic busy;
      logic accepted;
   } rsp_type;

endpackage

// ----- sv/dual_dac_spi_command_writer_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   operation, channel, value
// rsp_      out        rsp_valid / rsp_stall   chip_select, serial_clock, serial_data,
//                                              busy_res, accepted
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// One request or tick is taken per clock while req_stall is low; its result is
// registered and shows on rsp_. A two-entry output buffer (result register
// plus skid register) lets input keep flowing while one result waits;
// req_stall rises only when both entries are full. csr_ready is always high.
// Reset (synchronous) restores the register defaults, idles the sequencer and
// drives all pins high.

module dual_dac_spi_command_writer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ddac_spi_pkg::OP_W-1:0]         req_operation,
   input  logic [ddac_spi_pkg::CHAN_W-1:0]       req_channel,
   input  logic [ddac_spi_pkg::VALUE_W-1:0]      req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_chip_select,
   output logic                                  rsp_serial_clock,
   output logic                                  rsp_serial_data,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_accepted,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddac_spi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ddac_spi_pkg::CSR_DAT_W-1:0]    csr_data
);
   import ddac_spi_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_POWER  = 3'd1,
      PH_SETTLE = 3'd2,
      PH_HIGH   = 3'd3,
      PH_LOW    = 3'd4,
      PH_GUARD  = 3'd5
   } phase_type;

   // Configuration registers
   logic [HALF_W-1:0]  half_ff;
   logic [GUARD_W-1:0] guard_ff;
   logic [WAIT_W-1:0]  power_ff;
   logic [WAIT_W-1:0]  settle_ff;

   // Sequencer state; pins are {cs, clk, mosi}
   phase_type             phase_ff, phase_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [BITS_W-1:0]     bits_ff, bits_in;
   logic [WAIT_W-1:0]     wait_ff, wait_in;
   logic [1:0]            idx_ff, idx_in;
   logic [2:0]            pins_ff, pins_in;

   // Output buffer
   rsp_type rsp_ff, skid_ff, rsp_in;
   logic    rsp_valid_ff, skid_valid_ff;

   logic req_accept, rsp_take;
   logic load_frame, high_half, acc;
   logic [FRAME_BITS-1:0] load_word;
   logic [MV_W-1:0]       mv;
   logic [MV_W+RECIP_W-1:0] mv_prod;
   logic [SCALED_W-1:0]   mv_scaled;
   logic [VALUE_W-1:0]    code;
   op_type                op;

   assign op         = op_type'(req_operation);
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   // Millivolt to code conversion
   assign mv        = (req_value > VALUE_W'(MV_MAX)) ? MV_MAX : req_value[MV_W-1:0];
   assign mv_prod   = (MV_W+RECIP_W)'(mv) * (MV_W+RECIP_W)'(MV_RECIP);
   assign mv_scaled = mv_prod[MV_SHIFT +: SCALED_W];
   assign code      = (op == OP_WRITE_MV) ? (MV_OFFSET + VALUE_W'(mv_scaled)) : req_value;

   // Next sequencer state for the item at the input
   always_comb begin
      phase_in   = phase_ff;
      frame_in   = frame_ff;
      bits_in    = bits_ff;
      wait_in    = wait_ff;
      idx_in     = idx_ff;
      pins_in    = pins_ff;
      load_frame = 1'b0;
      high_half  = 1'b0;
      load_word  = {CMD_WRITE_UPDATE, ADDR_W'(req_channel[ADDR_W-1:0]), code};
      acc        = 1'b0;

      if (op == OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            if (wait_ff > WAIT_W'(1)) begin
               wait_in = wait_ff - WAIT_W'(1);
            end else begin
               unique case (phase_ff)
                  PH_POWER: begin
                     pins_in  = 3'b000;
                     phase_in = PH_SETTLE;
                     wait_in  = settle_ff;
                  end
                  PH_SETTLE: begin
                     idx_in     = 2'd2;
                     load_frame = 1'b1;
                     high_half  = 1'b1;
                     load_word  = FRAME_POWER_UP;
                  end
                  PH_HIGH: begin
                     pins_in  = {2'b00, pins_ff[0]};
                     phase_in = PH_LOW;
                     wait_in  = WAIT_W'(half_ff);
                  end
                  PH_LOW: begin
                     bits_in  = bits_ff - BITS_W'(1);
                     frame_in = {frame_ff[FRAME_BITS-2:0], 1'b0};
                     if (bits_in != '0) begin
                        high_half = 1'b1;
                     end else begin
                        pins_in  = {2'b10, pins_ff[0]};
                        phase_in = PH_GUARD;
                        wait_in  = WAIT_W'(guard_ff);
                     end
                  end
                  PH_GUARD: begin
                     if (idx_ff != 2'd0) begin
                        idx_in     = idx_ff - 2'd1;
                        load_frame = 1'b1;
                        high_half  = 1'b1;
                        load_word  = init_frame(idx_in);
                     end else begin
                        pins_in  = {2'b11, pins_ff[0]};
                        phase_in = PH_IDLE;
                        wait_in  = '0;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end else if (phase_ff == PH_IDLE) begin
         if (op == OP_INIT) begin
            pins_in  = 3'b111;
            phase_in = PH_POWER;
            wait_in  = power_ff;
            idx_in   = 2'd0;
            acc      = 1'b1;
         end else if (req_channel <= CHAN_W'(1)) begin
            idx_in     = 2'd0;
            load_frame = 1'b1;
            high_half  = 1'b1;
            acc        = 1'b1;
         end
      end

      // Frame start and clock-high half shared by several phases
      if (load_frame) begin
         frame_in = load_word;
         bits_in  = BITS_W'(FRAME_BITS);
      end
      if (high_half) begin
         pins_in  = {2'b01, frame_in[FRAME_BITS-1]};
         phase_in = PH_HIGH;
         wait_in  = WAIT_W'(half_ff);
      end

      rsp_in.chip_select  = pins_in[2];
      rsp_in.serial_clock = pins_in[1];
      rsp_in.serial_data  = pins_in[0];
      rsp_in.busy         = (phase_in != PH_IDLE);
      rsp_in.accepted     = acc;
   end

   // State, configuration and output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff       <= HALF_RST;
         guard_ff      <= GUARD_RST;
         power_ff      <= POWER_RST;
         settle_ff     <= SETTLE_RST;
         phase_ff      <= PH_IDLE;
         frame_ff      <= '0;
         bits_ff       <= '0;
         wait_ff       <= '0;
         idx_ff        <= '0;
         pins_ff       <= 3'b111;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HALF_PERIOD: half_ff   <= csr_data[HALF_W-1:0];
               CSR_GUARD:       guard_ff  <= csr_data[GUARD_W-1:0];
               CSR_POWER_WAIT:  power_ff  <= csr_data;
               CSR_SETTLE_WAIT: settle_ff <= csr_data;
               default: ;
            endcase
         end

         if (req_accept) begin
            phase_ff <= phase_in;
            frame_ff <= frame_in;
            bits_ff  <= bits_in;
            wait_ff  <= wait_in;
            idx_ff   <= idx_in;
            pins_ff  <= pins_in;
         end

         // Two-entry result buffer: skid feeds the result register first
         if (skid_valid_ff) begin
            if (rsp_take) begin
               rsp_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (rsp_valid_ff && !rsp_take) begin
               skid_ff       <= rsp_in;
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chip_select  = rsp_ff.chip_select;
   assign rsp_serial_clock = rsp_ff.serial_clock;
   assign rsp_serial_data  = rsp_ff.serial_data;
   assign rsp_busy_res     = rsp_ff.busy;
   assign rsp_accepted     = rsp_ff.accepted;

   // Skid entry only ever sits behind a full result register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry without result entry");

   // While shifting, chip select is low and bits remain
   a_shift_cs: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HIGH || phase_ff == PH_LOW) |-> (!pins_ff[2] && bits_ff != '0))
      else $error("frame shifting with chip select high or no bits left");

   // No init frames pending once idle
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (idx_ff == 2'd0))
      else $error("idle with init frames pending");

   // A finished frame hands over with the clock low and chip select high
   a_guard_pins: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GUARD) |-> (pins_ff[2] && !pins_ff[1]))
      else $error("guard phase with wrong pin levels");

endmodule
